// ===== hdl/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 16;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned OCC_W           = 5;
  localparam int unsigned CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } bdq_opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bdq_status_e;

  // Row-wide shift/write command, applied only for operations that succeed.
  typedef struct packed {
    logic               push_back;
    logic               push_front;
    logic               pop_front;
    logic [VALUE_W-1:0] value;
  } bdq_op_t;

endpackage
`default_nettype wire

// ===== hdl/bdq_cell.sv =====
`default_nettype none
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  wire                clk_i,
  input  bdq_op_t            op_i,
  input  wire [CntW-1:0]     count_i,
  input  wire [VALUE_W-1:0]  left_i,   // front-side neighbor (push value for the head cell)
  input  wire [VALUE_W-1:0]  right_i,  // back-side neighbor
  output logic [VALUE_W-1:0] data_o,
  output logic [VALUE_W-1:0] back_o    // own data when this cell is the back, else zero
);

  logic [VALUE_W-1:0] data_q, data_d;
  logic               at_tail;
  logic               is_back;

  assign at_tail = (count_i == CntW'(Idx));
  assign is_back = (count_i == CntW'(Idx + 1));

  always_comb begin
    data_d = data_q;
    if (op_i.push_front) begin
      data_d = left_i;
    end else if (op_i.pop_front) begin
      data_d = right_i;
    end else if (op_i.push_back && at_tail) begin
      data_d = op_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign back_o = is_back ? data_q : '0;

endmodule
`default_nettype wire

// ===== hdl/bounded_deque.sv =====
`default_nettype none
// Double-ended queue of signed 32-bit values held in a row of MaxEntries cells.
// The front element always sits in the first cell; a front push or front pop
// shifts the whole row by one cell, a back push writes the cell just past the
// last element, and a back pop reads the last element. Each transfer on the
// input side yields one result transfer; the result is held in an output
// register, so a new operation is taken in every cycle that the output side
// accepts (or while the output register is empty). Pushes beyond the capacity
// register (clamped to MaxEntries) report full, pops of an empty queue report
// empty with value -1. Write the capacity only while no operation is in
// flight.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int unsigned MaxEntries = DEF_MAX_ENTRIES
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] push_value
  input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] pop_value, [36:32] occupancy, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [4:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  logic [CAP_W-1:0]   cap_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  logic [VALUE_W-1:0] pop_value_q, pop_value_d;
  bdq_status_e        status_q, status_d;

  logic               accept;
  bdq_opcode_e        opcode;
  bdq_op_t            op;
  logic [CmpW-1:0]    cap_ext, max_ext, cnt_ext, limit;
  logic               full, empty;

  logic [VALUE_W-1:0] data_w [MaxEntries];
  logic [VALUE_W-1:0] back_w [MaxEntries];
  logic [VALUE_W-1:0] back_value;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign opcode        = bdq_opcode_e'(s_axis_tuser);

  assign cap_ext = CmpW'(cap_q);
  assign max_ext = CmpW'(MaxEntries);
  assign cnt_ext = CmpW'(count_q);
  assign limit   = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign full    = (cnt_ext >= limit);
  assign empty   = (count_q == '0);

  // Only one cell matches the back position, so OR-ing masked outputs selects it.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      back_value = back_value | back_w[i];
    end
  end

  always_comb begin
    op          = '0;
    op.value    = s_axis_tdata;
    count_d     = count_q;
    pop_value_d = '0;
    status_d    = ST_OK;
    case (opcode)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op.push_back  = accept && (opcode == OP_PUSH_BACK);
          op.push_front = accept && (opcode == OP_PUSH_FRONT);
          count_d       = count_q + CntW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_d    = ST_EMPTY;
          pop_value_d = '1;
        end else begin
          op.pop_front = accept && (opcode == OP_POP_FRONT);
          pop_value_d  = (opcode == OP_POP_FRONT) ? data_w[0] : back_value;
          count_d      = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic [VALUE_W-1:0] left, right;
    if (g == 0) begin : g_head
      assign left = s_axis_tdata;
    end else begin : g_mid
      assign left = data_w[g-1];
    end
    if (g == MaxEntries - 1) begin : g_tail
      assign right = data_w[g];
    end else begin : g_inner
      assign right = data_w[g+1];
    end

    bdq_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .count_i (count_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (data_w[g]),
      .back_o  (back_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
    end
  end

  logic [OCC_W-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      occ_q <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, pop_value_q};
  assign m_axis_tuser  = status_q;

endmodule
`default_nettype wire
